FILE: design/grid_local_maximum_detector_assert.svh
// Assertion macros shared by the design files.
// Each macro takes a label, an antecedent, a consequent and a message string.
`ifndef GRID_LOCAL_MAXIMUM_DETECTOR_ASSERT_SVH
`define GRID_LOCAL_MAXIMUM_DETECTOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GLMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GLMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/glmd_pkg.sv
`default_nettype none

package glmd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIXEL_BITS = 8;

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int ROW_BITS = $clog2(MAX_HEIGHT);

  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [PIXEL_BITS-1:0] value;
    logic [ROW_BITS-1:0]   row;
    logic [COL_BITS-1:0]   col;
    logic                  is_peak;
    logic                  none_found;
    logic                  frame_done;
  } res_t;

  // Up to two results per pixel: a peak report, then the frame summary.
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

`default_nettype wire

FILE: design/grid_local_maximum_detector.sv
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | to block  | in_valid_i/in_stall_o  | pixel_value_i
//  out     | from block| out_valid_o/out_stall_i| peak_value_o peak_row_o peak_col_o is_peak_o
//          |           |                        | none_found_o frame_done_o
//  cfg     | to block  | cfg_we_i               | cfg_index_i cfg_data_i
//
//  One pixel per cycle sustained while in_stall_o is low: the line store banks take one
//  write and two reads per cycle, and a result passes the second stage into an 8-beat queue.
//  Each configuration write holds the input off while the left-neighbour register
//  is reloaded from the middle-row bank.
//  Reset clears counters, bank select and queue; line stores are not cleared.
//  Input stall rises when the queue may not have room for two more beats.
`default_nettype none

`include "grid_local_maximum_detector_assert.svh"

module grid_local_maximum_detector (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [glmd_pkg::PIXEL_BITS-1:0]     pixel_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [glmd_pkg::PIXEL_BITS-1:0]     peak_value_o,
  output logic      [glmd_pkg::ROW_BITS-1:0]       peak_row_o,
  output logic      [glmd_pkg::COL_BITS-1:0]       peak_col_o,
  output logic                                    is_peak_o,
  output logic                                    none_found_o,
  output logic                                    frame_done_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [glmd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [glmd_pkg::CFG_BITS-1:0]       cfg_data_i
);
  import glmd_pkg::*;

  localparam int ROOM_LIMIT = FIFO_DEPTH - 2;

  logic [COL_BITS-1:0]      w_last_q, w_last_d;
  logic [ROW_BITS-1:0]      h_last_q, h_last_d;
  logic [COL_BITS-1:0]      w_new;
  logic [ROW_BITS-1:0]      h_new;
  logic                     rf_req_q, rf_cap_q, rf_issue;
  logic                     accept, busy, room;
  logic [FIFO_CNT_BITS:0]   fill;
  logic [FIFO_CNT_BITS-1:0] fifo_count;
  push_t                    push;
  res_t                     head;

  // Turn a written size into the index of the last column or row.
  always_comb begin
    if (cfg_data_i == '0) begin
      w_new = '0;
    end else if (cfg_data_i > CFG_BITS'(MAX_WIDTH)) begin
      w_new = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_new = COL_BITS'(cfg_data_i - CFG_BITS'(1));
    end
    if (cfg_data_i == '0) begin
      h_new = '0;
    end else if (cfg_data_i > CFG_BITS'(MAX_HEIGHT)) begin
      h_new = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      h_new = ROW_BITS'(cfg_data_i - CFG_BITS'(1));
    end
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  w_last_d = w_new;
        REG_FRAME_HEIGHT: h_last_d = h_new;
        default: ;
      endcase
    end
  end

  always_comb begin
    rf_issue   = rf_req_q && !cfg_we_i;
    fill       = {1'b0, fifo_count} + (busy ? (FIFO_CNT_BITS + 1)'(2) : '0);
    room       = (fill <= (FIFO_CNT_BITS + 1)'(ROOM_LIMIT));
    in_stall_o = cfg_we_i || rf_req_q || rf_cap_q || !room;
    accept     = in_valid_i && !in_stall_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= COL_BITS'(MAX_WIDTH - 1);
      h_last_q <= ROW_BITS'(MAX_HEIGHT - 1);
      rf_req_q <= 1'b0;
      rf_cap_q <= 1'b0;
    end else begin
      w_last_q <= w_last_d;
      h_last_q <= h_last_d;
      rf_req_q <= cfg_we_i;
      rf_cap_q <= rf_issue;
    end
  end

  glmd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .pixel_i    (pixel_value_i),
    .w_last_i   (w_last_q),
    .h_last_i   (h_last_q),
    .rf_issue_i (rf_issue),
    .rf_cap_i   (rf_cap_q),
    .busy_o     (busy),
    .push_o     (push)
  );

  glmd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && !out_stall_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (fifo_count)
  );

  assign peak_value_o = head.value;
  assign peak_row_o   = head.row;
  assign peak_col_o   = head.col;
  assign is_peak_o    = head.is_peak;
  assign none_found_o = head.none_found;
  assign frame_done_o = head.frame_done;

  `GLMD_ASSERT_NEXT(a_cfg_holds_input, cfg_we_i, in_stall_o, "beat taken during refill")
  `GLMD_ASSERT_NOW(a_peak_interior, out_valid_o && is_peak_o,
                   peak_row_o != '0 && peak_col_o != '0, "border element reported")
  `GLMD_ASSERT_NOW(a_summary_kind, out_valid_o && frame_done_o,
                   !is_peak_o && peak_value_o == '0, "summary beat carries a peak")

endmodule

`default_nettype wire

FILE: design/glmd_line_ram.sv
`default_nettype none

module glmd_line_ram (
  input  wire logic                           clk_i,
  input  wire logic                           we_i,
  input  wire logic [glmd_pkg::COL_BITS-1:0]   waddr_i,
  input  wire logic [glmd_pkg::PIXEL_BITS-1:0] wdata_i,
  input  wire logic [glmd_pkg::COL_BITS-1:0]   raddr_a_i,
  input  wire logic [glmd_pkg::COL_BITS-1:0]   raddr_b_i,
  output logic      [glmd_pkg::PIXEL_BITS-1:0] rdata_a_o,
  output logic      [glmd_pkg::PIXEL_BITS-1:0] rdata_b_o
);
  import glmd_pkg::*;

  logic [PIXEL_BITS-1:0] mem [MAX_WIDTH];

  // Read returns the old entry when the same address is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: design/glmd_core.sv
`default_nettype none

module glmd_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           accept_i,
  input  wire logic [glmd_pkg::PIXEL_BITS-1:0] pixel_i,
  input  wire logic [glmd_pkg::COL_BITS-1:0]   w_last_i,
  input  wire logic [glmd_pkg::ROW_BITS-1:0]   h_last_i,
  input  wire logic                           rf_issue_i,
  input  wire logic                           rf_cap_i,
  output logic                                busy_o,
  output glmd_pkg::push_t                     push_o
);
  import glmd_pkg::*;

  logic [COL_BITS-1:0]   col_q, col_d;
  logic [ROW_BITS-1:0]   row_q, row_d;
  logic                  bank_q, bank_d;
  logic                  found_q, found_d;

  logic [COL_BITS-1:0]   c_a;
  logic [ROW_BITS-1:0]   r_a;
  logic                  last_col, last_row, judge_a;
  logic [COL_BITS-1:0]   raddr_a, raddr_b;

  logic [PIXEL_BITS-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

  logic                  sb_v_q;
  logic [PIXEL_BITS-1:0] sb_px_q;
  logic [COL_BITS-1:0]   sb_c_q;
  logic [ROW_BITS-1:0]   sb_r_q;
  logic                  sb_judge_q, sb_end_q, sb_bank_q;

  logic [PIXEL_BITS-1:0] win_l_q;
  logic [PIXEL_BITS-1:0] top_px, mid_c, mid_n;
  logic                  peak;
  res_t                  peak_res, sum_res;

  // Position of the arriving pixel, pulled onto the last column or row.
  always_comb begin
    c_a      = (col_q < w_last_i) ? col_q : w_last_i;
    r_a      = (row_q < h_last_i) ? row_q : h_last_i;
    last_col = (c_a == w_last_i);
    last_row = (r_a == h_last_i);
    judge_a  = (r_a >= ROW_BITS'(2)) && (c_a != '0) && (c_a < w_last_i);
    raddr_a  = rf_issue_i ? (c_a - COL_BITS'(1)) : c_a;
    raddr_b  = c_a + COL_BITS'(1);
  end

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    bank_d = bank_q;
    if (accept_i) begin
      if (last_col) begin
        col_d  = '0;
        bank_d = ~bank_q;
        if (last_row) begin
          row_d  = '0;
          bank_d = 1'b0;
        end else begin
          row_d = r_a + ROW_BITS'(1);
        end
      end else begin
        col_d = c_a + COL_BITS'(1);
        row_d = r_a;
      end
    end
  end

  // Bank 0 and bank 1 swap the roles of oldest row and middle row each line.
  glmd_line_ram u_bank0 (
    .clk_i     (clk_i),
    .we_i      (accept_i && !bank_q),
    .waddr_i   (c_a),
    .wdata_i   (pixel_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd0_a),
    .rdata_b_o (rd0_b)
  );

  glmd_line_ram u_bank1 (
    .clk_i     (clk_i),
    .we_i      (accept_i && bank_q),
    .waddr_i   (c_a),
    .wdata_i   (pixel_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd1_a),
    .rdata_b_o (rd1_b)
  );

  // Second stage: memory data has arrived, judge the middle-row element.
  always_comb begin
    top_px = sb_bank_q ? rd1_a : rd0_a;
    mid_c  = sb_bank_q ? rd0_a : rd1_a;
    mid_n  = sb_bank_q ? rd0_b : rd1_b;
    peak   = sb_v_q && sb_judge_q && (mid_c > top_px) && (mid_c > sb_px_q)
             && (mid_c > win_l_q) && (mid_c > mid_n);
    found_d = found_q;
    if (sb_v_q) begin
      found_d = sb_end_q ? 1'b0 : (found_q | peak);
    end

    peak_res.value      = mid_c;
    peak_res.row        = sb_r_q - ROW_BITS'(1);
    peak_res.col        = sb_c_q;
    peak_res.is_peak    = 1'b1;
    peak_res.none_found = 1'b0;
    peak_res.frame_done = 1'b0;

    sum_res.value      = '0;
    sum_res.row        = '0;
    sum_res.col        = '0;
    sum_res.is_peak    = 1'b0;
    sum_res.none_found = ~(found_q | peak);
    sum_res.frame_done = 1'b1;

    push_o.v0 = peak || (sb_v_q && sb_end_q);
    push_o.v1 = peak && sb_end_q;
    push_o.r0 = peak ? peak_res : sum_res;
    push_o.r1 = sum_res;
  end

  assign busy_o = sb_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      bank_q  <= 1'b0;
      found_q <= 1'b0;
      sb_v_q  <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      bank_q  <= bank_d;
      found_q <= found_d;
      sb_v_q  <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      sb_px_q    <= pixel_i;
      sb_c_q     <= c_a;
      sb_r_q     <= r_a;
      sb_judge_q <= judge_a;
      sb_end_q   <= last_col && last_row;
      sb_bank_q  <= bank_q;
    end
    // Refill after a geometry change reloads the left neighbour from the middle row.
    if (rf_cap_i) begin
      win_l_q <= bank_q ? rd0_a : rd1_a;
    end else if (sb_v_q) begin
      win_l_q <= mid_c;
    end
  end

endmodule

`default_nettype wire

FILE: design/glmd_out_fifo.sv
`default_nettype none

`include "grid_local_maximum_detector_assert.svh"

module glmd_out_fifo (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire glmd_pkg::push_t                   push_i,
  input  wire logic                              pop_i,
  output logic                                   valid_o,
  output glmd_pkg::res_t                         head_o,
  output logic [glmd_pkg::FIFO_CNT_BITS-1:0]     count_o
);
  import glmd_pkg::*;

  res_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_q, rd_q;
  logic [FIFO_CNT_BITS-1:0] count_q;
  logic [FIFO_PTR_BITS-1:0] wr_nxt;
  logic [1:0]               n_push;

  always_comb begin
    wr_nxt = wr_q + FIFO_PTR_BITS'(1);
    n_push = {1'b0, push_i.v0} + {1'b0, push_i.v1};
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem[wr_q] <= push_i.r0;
    end
    if (push_i.v1) begin
      mem[wr_nxt] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_q + FIFO_PTR_BITS'(n_push);
      rd_q    <= rd_q + FIFO_PTR_BITS'(pop_i);
      count_q <= count_q + FIFO_CNT_BITS'(n_push) - FIFO_CNT_BITS'(pop_i);
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = mem[rd_q];
  assign count_o = count_q;

  `GLMD_ASSERT_NOW(a_fifo_bound, 1'b1, count_q <= FIFO_CNT_BITS'(FIFO_DEPTH), "fifo overrun")
  `GLMD_ASSERT_NOW(a_fifo_pair, push_i.v1, push_i.v0, "second beat pushed without first")
  `GLMD_ASSERT_NEXT(a_fifo_drain, pop_i && !push_i.v0,
                    count_q == $past(count_q) - FIFO_CNT_BITS'(1), "fifo count lost a beat")

endmodule

`default_nettype wire

FILE: tb/grid_peak_checker.sv
`timescale 1ns / 100ps
`default_nettype none

module grid_peak_checker (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               in_stall_i,
  input  wire logic [glmd_pkg::PIXEL_BITS-1:0]     pixel_value_i,
  input  wire logic                               out_valid_i,
  input  wire logic                               out_stall_i,
  input  wire logic [glmd_pkg::PIXEL_BITS-1:0]     peak_value_i,
  input  wire logic [glmd_pkg::ROW_BITS-1:0]       peak_row_i,
  input  wire logic [glmd_pkg::COL_BITS-1:0]       peak_col_i,
  input  wire logic                               is_peak_i,
  input  wire logic                               none_found_i,
  input  wire logic                               frame_done_i,
  input  wire logic                               cfg_we_i,
  input  wire logic [glmd_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [glmd_pkg::CFG_BITS-1:0]       cfg_data_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  import glmd_pkg::*;

  logic [CFG_BITS-1:0]   cfg_width  = CFG_BITS'(MAX_WIDTH);
  logic [CFG_BITS-1:0]   cfg_height = CFG_BITS'(MAX_HEIGHT);
  logic [PIXEL_BITS-1:0] line_buf [2][MAX_WIDTH];
  logic                  bank       = 1'b0;
  int                    row_pos    = 0;
  int                    col_pos    = 0;
  logic                  peak_seen  = 1'b0;
  res_t                  expected_peaks [$];
  int                    fails      = 0;
  int                    waiting    = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic int eff_dim(input logic [CFG_BITS-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // Judge the element one row above the incoming pixel, then store the pixel.
  task automatic judge_pixel(input logic [PIXEL_BITS-1:0] px);
    int w;
    int h;
    int c;
    int r;
    logic [PIXEL_BITS-1:0] ctr;
    res_t e;
    w = eff_dim(cfg_width, MAX_WIDTH);
    h = eff_dim(cfg_height, MAX_HEIGHT);
    c = (col_pos < w - 1) ? col_pos : w - 1;
    r = (row_pos < h - 1) ? row_pos : h - 1;
    if (r >= 2 && c >= 1 && c + 1 < w) begin
      ctr = line_buf[~bank][c];
      if (ctr > line_buf[bank][c] && ctr > px &&
          ctr > line_buf[~bank][c-1] && ctr > line_buf[~bank][c+1]) begin
        e.value      = ctr;
        e.row        = ROW_BITS'(r - 1);
        e.col        = COL_BITS'(c);
        e.is_peak    = 1'b1;
        e.none_found = 1'b0;
        e.frame_done = 1'b0;
        expected_peaks.push_back(e);
        peak_seen = 1'b1;
      end
    end
    line_buf[bank][c] = px;
    if (c == w - 1) begin
      col_pos = 0;
      bank    = ~bank;
      if (r == h - 1) begin
        e.value      = '0;
        e.row        = '0;
        e.col        = '0;
        e.is_peak    = 1'b0;
        e.none_found = ~peak_seen;
        e.frame_done = 1'b1;
        expected_peaks.push_back(e);
        row_pos   = 0;
        peak_seen = 1'b0;
        bank      = 1'b0;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_FRAME_WIDTH) begin
          cfg_width = cfg_data_i;
        end else if (cfg_index_i == REG_FRAME_HEIGHT) begin
          cfg_height = cfg_data_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        judge_pixel(pixel_value_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_peaks.size() == 0) begin
          $error("unexpected result beat: value %0d row %0d col %0d peak %0b none %0b done %0b",
                 peak_value_i, peak_row_i, peak_col_i, is_peak_i, none_found_i,
                 frame_done_i);
          fails++;
        end else begin
          e = expected_peaks.pop_front();
          compare_field("peak_value", int'(e.value), int'(peak_value_i));
          compare_field("peak_row", int'(e.row), int'(peak_row_i));
          compare_field("peak_col", int'(e.col), int'(peak_col_i));
          compare_field("is_peak", int'(e.is_peak), int'(is_peak_i));
          compare_field("none_found", int'(e.none_found), int'(none_found_i));
          compare_field("frame_done", int'(e.frame_done), int'(frame_done_i));
        end
      end
      waiting = expected_peaks.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/grid_local_maximum_detector_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module grid_local_maximum_detector_tb;

  import glmd_pkg::*;

  localparam int LIMIT = 400_000;

  typedef enum int {PAT_UNIFORM, PAT_FLAT, PAT_SPIKY} pattern_e;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [PIXEL_BITS-1:0]   pixel;
  logic                    out_valid;
  logic                    out_stall;
  logic [PIXEL_BITS-1:0]   peak_value;
  logic [ROW_BITS-1:0]     peak_row;
  logic [COL_BITS-1:0]     peak_col;
  logic                    is_peak;
  logic                    none_found;
  logic                    frame_done;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;
  int                      fail_count;
  int                      pending;
  int                      cycle_count = 0;
  logic                    tx_calm = 1'b0;
  logic                    rx_calm = 1'b0;

  grid_local_maximum_detector u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pixel_value_i (pixel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .peak_value_o  (peak_value),
    .peak_row_o    (peak_row),
    .peak_col_o    (peak_col),
    .is_peak_o     (is_peak),
    .none_found_o  (none_found),
    .frame_done_o  (frame_done),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  grid_peak_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .pixel_value_i (pixel),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .peak_value_i  (peak_value),
    .peak_row_i    (peak_row),
    .peak_col_i    (peak_col),
    .is_peak_i     (is_peak),
    .none_found_i  (none_found),
    .frame_done_i  (frame_done),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int eff_dim(input int v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    pixel    <= px;
    do @(posedge clk); while (in_stall);
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold the input off until every expected result has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic program_geometry(input int w, input int h);
    drain();
    // let the pipeline clear before the geometry changes
    repeat (8) @(negedge clk);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  task automatic run_frame(input int w, input int h, input pattern_e pat, output int sent);
    int n;
    int pause_at;
    logic [PIXEL_BITS-1:0] base;
    logic [PIXEL_BITS-1:0] px;
    program_geometry(w, h);
    tx_calm  = ($urandom_range(0, 3) == 0);
    rx_calm  = ($urandom_range(0, 3) == 0);
    n        = eff_dim(w, MAX_WIDTH) * eff_dim(h, MAX_HEIGHT);
    pause_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, n - 1)) : -1;
    base     = PIXEL_BITS'($urandom_range(0, 253));
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain();
      case (pat)
        PAT_FLAT:  px = PIXEL_BITS'(base + $urandom_range(0, 2));
        PAT_SPIKY: px = ($urandom_range(0, 5) == 0) ? PIXEL_BITS'($urandom_range(128, 255))
                                                     : PIXEL_BITS'($urandom_range(0, 127));
        default:   px = PIXEL_BITS'($urandom_range(0, 255));
      endcase
      send_pixel(px);
    end
    sent = n;
  endtask

  // Result side: stall for a drawn number of cycles, then take one beat.
  initial begin
    int wt;
    out_stall = 1'b0;
    forever begin
      wt = rx_calm ? 0 : $urandom_range(0, 18);
      if (wt > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (wt - 1) @(negedge clk);
        @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    logic [PIXEL_BITS-1:0] peak_grid [9];
    logic [PIXEL_BITS-1:0] tie_grid [9];
    int random_items;
    int sent;
    int w;
    int h;
    pattern_e pat;
    peak_grid    = '{8'd0, 8'd254, 8'd0, 8'd254, 8'd255, 8'd254, 8'd0, 8'd254, 8'd0};
    tie_grid     = '{8'd3, 8'd3, 8'd3, 8'd9, 8'd9, 8'd3, 8'd3, 8'd3, 8'd3};
    random_items = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    pixel        = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_FRAME_WIDTH;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // single interior peak at full scale, with a drained pause mid-frame
    program_geometry(3, 3);
    for (int i = 0; i < 9; i++) begin
      if (i == 5) drain();
      send_pixel(peak_grid[i]);
    end
    // centre ties with its left neighbour: no peak
    for (int i = 0; i < 9; i++) send_pixel(tie_grid[i]);
    // one-element frame
    program_geometry(1, 1);
    send_pixel(8'd0);

    // zero-sized registers and narrow geometries
    run_frame(0, 6, PAT_UNIFORM, sent);
    random_items += sent;
    run_frame(8, 0, PAT_UNIFORM, sent);
    random_items += sent;
    run_frame(2, 4, PAT_FLAT, sent);
    random_items += sent;
    run_frame(3, 24, PAT_SPIKY, sent);
    random_items += sent;

    while (random_items < 1000) begin
      w   = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h   = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 10);
      if ($urandom_range(0, 19) == 0) w = 0;
      if ($urandom_range(0, 19) == 0) h = 0;
      pat = pattern_e'($urandom_range(0, 2));
      run_frame(w, h, pat, sent);
      random_items += sent;
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
